FILE: design/ofd_pkg.sv
package ofd_pkg;

  localparam int SYMBOL_SLOTS = 32;
  localparam int SYM_W        = $clog2(SYMBOL_SLOTS);
  localparam int ORDER_W      = 6;
  localparam int WINDOW_BITS  = 20;
  localparam int AVAIL_W      = 5;

  // Opcode codes, grouped by operand count
  localparam logic [2:0] OPC_PAIR_0   = 3'b000;
  localparam logic [2:0] OPC_PAIR_3   = 3'b011;
  localparam logic [2:0] OPC_PAIR_4   = 3'b100;
  localparam logic [2:0] OPC_SINGLE_1 = 3'b001;
  localparam logic [2:0] OPC_SINGLE_5 = 3'b101;
  localparam logic [2:0] OPC_SINGLE_6 = 3'b110;
  localparam logic [2:0] OPC_SINGLE_7 = 3'b111;
  localparam logic [2:0] OPC_NONE_2   = 3'b010;

  // Operand kinds
  localparam logic [1:0] KIND_VALUE = 2'd0;
  localparam logic [1:0] KIND_REG   = 2'd1;
  localparam logic [1:0] KIND_STACK = 2'd2;
  localparam logic [1:0] KIND_PTR   = 2'd3;

  // Field lengths in stream bits
  localparam logic [AVAIL_W-1:0] LEN_KIND  = AVAIL_W'(2);
  localparam logic [AVAIL_W-1:0] LEN_VALUE = AVAIL_W'(8);
  localparam logic [AVAIL_W-1:0] LEN_REG   = AVAIL_W'(3);
  localparam logic [AVAIL_W-1:0] LEN_SYM   = AVAIL_W'(SYM_W);

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_SHORT = 1'b1;

  // One decoded operand waiting for its table read
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] val;       // final value unless from_mem
    logic       from_mem;  // value comes from the order table
    logic       bank;      // 0: bank A, 1: bank B
  } op_info_t;

  function automatic logic [AVAIL_W-1:0] value_len(input logic [1:0] kind);
    logic [AVAIL_W-1:0] len;
    unique case (kind)
      KIND_VALUE: len = LEN_VALUE;
      KIND_REG:   len = LEN_REG;
      default:    len = LEN_SYM;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] raw_value(input logic [1:0] kind, input logic [7:0] f);
    logic [7:0] v;
    unique case (kind)
      KIND_VALUE: v = f;
      KIND_REG:   v = {5'b0, f[2:0]};
      default:    v = 8'(f[SYM_W-1:0]);
    endcase
    return v;
  endfunction

endpackage

FILE: design/operand_field_decoder_unit.sv
// operand_field_decoder_unit
// Input channel (in_valid/in_ready): one item per instruction with a 3-bit
// opcode, a 20-bit window of upcoming stream bits (first bit at bit 0), the
// count of valid window bits and a new_scope flag that clears the symbol
// renaming first.
// Result channel (out_valid/out_ready): one item per input item with operand
// kinds and values, bits consumed, operand count and a shortage status.
//
// Output: an accepted item is registered in the result stage and offered on out_* in the next cycle.
// Throughput: one item per cycle unless a stalled result holds in_ready low.
// The symbol order table is two 32x6 synchronous banks (one write port each,
// two reads each); an item issues its reads at accept and the registered read
// data resolves the values in the next cycle, alongside the result stage. Slot
// valid bits, bank select bits and the order counter are flops updated at
// accept, so a following item already sees this item's assignments.
//
// Reset: all slots unassigned, counter zero, result stage empty. The banks
// themselves are not cleared; valid bits mask them.
// Stall: while out_ready is low a held result blocks in_ready, and the bank
// reads are frozen so the pending read data stays put.
module operand_field_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [19:0] in_operand_bits,
  input  logic [4:0]  in_bits_available,
  input  logic        in_new_scope,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_operand_count,
  output logic [1:0]  out_first_kind,
  output logic [7:0]  out_first_value,
  output logic [1:0]  out_second_kind,
  output logic [7:0]  out_second_value,
  output logic [4:0]  out_bits_used,
  output logic        out_status
);

  localparam int SW = ofd_pkg::SYM_W;
  localparam int OW = ofd_pkg::ORDER_W;
  localparam int AW = ofd_pkg::AVAIL_W;

  // ---------------------------------------------------------------
  // State
  // ---------------------------------------------------------------
  logic [ofd_pkg::SYMBOL_SLOTS-1:0] valid_r;
  logic [ofd_pkg::SYMBOL_SLOTS-1:0] bank_sel_r;
  logic [OW-1:0]                    cnt_r;

  logic [OW-1:0] bank_a [ofd_pkg::SYMBOL_SLOTS];
  logic [OW-1:0] bank_b [ofd_pkg::SYMBOL_SLOTS];
  logic [OW-1:0] rd_a0_r, rd_a1_r, rd_b0_r, rd_b1_r;

  // Result stage
  logic              s2_valid_r;
  ofd_pkg::op_info_t op1_r, op2_r;
  logic [1:0]        count_r;
  logic [AW-1:0]     used_r;
  logic              status_r;

  logic accept;
  assign in_ready = !s2_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // ---------------------------------------------------------------
  // Field parsing: positions depend only on the kinds
  // ---------------------------------------------------------------
  logic [1:0]    op_count;
  logic [1:0]    kind1, kind2;
  logic [7:0]    f1, f2;
  logic [19:0]   w2;
  logic [AW-1:0] pos1, need, avail_c;
  logic          short_c;
  logic [SW-1:0] s1, s2;

  always_comb begin
    unique case (in_opcode) inside
      ofd_pkg::OPC_PAIR_0, ofd_pkg::OPC_PAIR_3, ofd_pkg::OPC_PAIR_4:
        op_count = 2'd2;
      ofd_pkg::OPC_NONE_2:
        op_count = 2'd0;
      default:
        op_count = 2'd1;
    endcase
  end

  always_comb begin
    kind1 = in_operand_bits[1:0];
    f1    = in_operand_bits[9:2];
    pos1  = ofd_pkg::LEN_KIND + ofd_pkg::value_len(kind1);
    unique case (kind1)
      ofd_pkg::KIND_VALUE: w2 = in_operand_bits >> 10;
      ofd_pkg::KIND_REG:   w2 = in_operand_bits >> 5;
      default:             w2 = in_operand_bits >> 7;
    endcase
    kind2 = w2[1:0];
    f2    = w2[9:2];
    s1    = f1[SW-1:0];
    s2    = f2[SW-1:0];

    avail_c = (in_bits_available > AW'(ofd_pkg::WINDOW_BITS)) ?
              AW'(ofd_pkg::WINDOW_BITS) : in_bits_available;
    case (op_count)
      2'd0:    need = '0;
      2'd1:    need = pos1;
      default: need = pos1 + ofd_pkg::LEN_KIND + ofd_pkg::value_len(kind2);
    endcase
    short_c = need > avail_c;
  end

  // ---------------------------------------------------------------
  // Renaming against the flop-held slot state
  // ---------------------------------------------------------------
  logic [ofd_pkg::SYMBOL_SLOTS-1:0] vld_eff;
  logic [OW-1:0] cnt_eff, cnt_a, cnt_b;
  logic          sym1, sym2, new1, new2, fwd2, use1, use2, wr_ok;
  ofd_pkg::op_info_t op1_c, op2_c;

  always_comb begin
    vld_eff = in_new_scope ? '0 : valid_r;
    cnt_eff = in_new_scope ? '0 : cnt_r;
    use1    = (op_count != 2'd0) && !short_c;
    use2    = (op_count == 2'd2) && !short_c;
    wr_ok   = accept && !short_c;

    sym1  = kind1[1];
    sym2  = kind2[1];
    new1  = use1 && sym1 && !vld_eff[s1];
    cnt_a = cnt_eff + OW'(new1);
    // second operand repeats a symbol the first one just assigned
    fwd2  = new1 && sym2 && (s1 == s2);
    new2  = use2 && sym2 && !vld_eff[s2] && !fwd2;
    cnt_b = cnt_a + OW'(new2);

    op1_c = '0;
    if (use1) begin
      op1_c.kind     = kind1;
      op1_c.val      = new1 ? 8'(cnt_eff) : ofd_pkg::raw_value(kind1, f1);
      op1_c.from_mem = sym1 && !new1;
      op1_c.bank     = bank_sel_r[s1];
    end
    op2_c = '0;
    if (use2) begin
      op2_c.kind     = kind2;
      op2_c.val      = fwd2 ? 8'(cnt_eff) :
                       new2 ? 8'(cnt_a) : ofd_pkg::raw_value(kind2, f2);
      op2_c.from_mem = sym2 && !new2 && !fwd2;
      op2_c.bank     = bank_sel_r[s2];
    end
  end

  // ---------------------------------------------------------------
  // Slot state and counter
  // ---------------------------------------------------------------
  logic [ofd_pkg::SYMBOL_SLOTS-1:0] valid_nxt, bank_sel_nxt;
  logic [OW-1:0]                    cnt_nxt;

  always_comb begin
    valid_nxt    = valid_r;
    bank_sel_nxt = bank_sel_r;
    cnt_nxt      = cnt_r;
    if (accept) begin
      valid_nxt = vld_eff;
      cnt_nxt   = cnt_eff;
      if (!short_c) begin
        cnt_nxt = cnt_b;
        if (new1) begin
          valid_nxt[s1]    = 1'b1;
          bank_sel_nxt[s1] = 1'b0;
        end
        if (new2) begin
          valid_nxt[s2]    = 1'b1;
          bank_sel_nxt[s2] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      cnt_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
    bank_sel_r <= bank_sel_nxt;
  end

  // ---------------------------------------------------------------
  // Order table banks: bank A takes first-operand assignments,
  // bank B second-operand ones. Reads only on accept.
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_a0_r <= bank_a[s1];
      rd_a1_r <= bank_a[s2];
      rd_b0_r <= bank_b[s1];
      rd_b1_r <= bank_b[s2];
    end
    if (wr_ok && new1) begin
      bank_a[s1] <= cnt_eff;
    end
    if (wr_ok && new2) begin
      bank_b[s2] <= cnt_a;
    end
  end

  // ---------------------------------------------------------------
  // Result stage
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (in_ready) begin
      s2_valid_r <= in_valid;
    end
    if (accept) begin
      op1_r    <= op1_c;
      op2_r    <= op2_c;
      count_r  <= short_c ? 2'd0 : op_count;
      used_r   <= short_c ? '0 : need;
      status_r <= short_c ? ofd_pkg::STATUS_SHORT : ofd_pkg::STATUS_OK;
    end
  end

  assign out_valid         = s2_valid_r;
  assign out_operand_count = count_r;
  assign out_first_kind    = op1_r.kind;
  assign out_second_kind   = op2_r.kind;
  assign out_bits_used     = used_r;
  assign out_status        = status_r;
  assign out_first_value   = !op1_r.from_mem ? op1_r.val :
                             8'(op1_r.bank ? rd_b0_r : rd_a0_r);
  assign out_second_value  = !op2_r.from_mem ? op2_r.val :
                             8'(op2_r.bank ? rd_b1_r : rd_a1_r);

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  // counter equals the number of assigned slots in the current scope
  a_cnt_matches_slots: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == OW'($countones(valid_r)))
    else $error("order counter out of step with slot valid bits");

  // a held result keeps its table read data
  a_stall_holds_read: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && !out_ready |=> $stable(rd_a0_r) && $stable(rd_a1_r) &&
                                 $stable(rd_b0_r) && $stable(rd_b1_r))
    else $error("table read data changed under a stalled result");

  // a shortage reports nothing but its status
  a_short_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_operand_count == 2'd0 &&
      out_bits_used == '0 && out_first_kind == '0 && out_second_kind == '0)
    else $error("shortage result carries operand data");

  // at most two new symbols per item, and none on a shortage
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_new_scope |=> (cnt_r == $past(cnt_r)) ||
      (cnt_r == $past(cnt_r) + OW'(1)) || (cnt_r == $past(cnt_r) + OW'(2)))
    else $error("order counter advanced by more than two");

endmodule

FILE: tb/sv/operand_field_decoder_unit_tb.sv
module operand_field_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One decoded operation as the result channel presents it
  typedef struct packed {
    logic [1:0] count;
    logic [1:0] kind_a;
    logic [7:0] value_a;
    logic [1:0] kind_b;
    logic [7:0] value_b;
    logic [4:0] used;
    logic       status;
  } decode_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_opcode;
  logic [19:0] in_operand_bits;
  logic [4:0]  in_bits_available;
  logic        in_new_scope;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_operand_count;
  logic [1:0]  out_first_kind;
  logic [7:0]  out_first_value;
  logic [1:0]  out_second_kind;
  logic [7:0]  out_second_value;
  logic [4:0]  out_bits_used;
  logic        out_status;

  // Predictor state: symbol renaming for the current scope
  logic [ofd_pkg::ORDER_W-1:0] order_of_symbol [ofd_pkg::SYMBOL_SLOTS];
  logic                        symbol_seen     [ofd_pkg::SYMBOL_SLOTS];
  logic [ofd_pkg::ORDER_W-1:0] next_order;

  decode_result_t expected_decodes[$];

  // Idle rates in percent per cycle, and the receiver's hold-off counter
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;

  int errors;
  int items_sent;
  int results_checked;
  int short_items;
  int scope_clears;

  operand_field_decoder_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_operand_bits   (in_operand_bits),
    .in_bits_available (in_bits_available),
    .in_new_scope      (in_new_scope),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_operand_count (out_operand_count),
    .out_first_kind    (out_first_kind),
    .out_first_value   (out_first_value),
    .out_second_kind   (out_second_kind),
    .out_second_value  (out_second_value),
    .out_bits_used     (out_bits_used),
    .out_status        (out_status)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Operands that follow each opcode
  function automatic int operand_total(input logic [2:0] op);
    int n;
    case (op) inside
      ofd_pkg::OPC_PAIR_0, ofd_pkg::OPC_PAIR_3, ofd_pkg::OPC_PAIR_4: n = 2;
      ofd_pkg::OPC_NONE_2:                                           n = 0;
      default:                                                       n = 1;
    endcase
    return n;
  endfunction

  // Stream bits of one operand: {length, bits}, kind in the low two bits
  function automatic logic [14:0] encode_operand(input logic [1:0] kind,
                                                 input logic [7:0] val);
    int len;
    int unsigned bits;
    case (kind)
      ofd_pkg::KIND_VALUE: len = 10;
      ofd_pkg::KIND_REG:   len = 5;
      default:             len = 7;
    endcase
    bits = {val, kind};
    bits = bits & ((32'd1 << len) - 1);
    return {5'(len), 10'(bits)};
  endfunction

  // Window holding n operands back to back: {bits used, window}
  function automatic logic [24:0] pack_operands(input int n,
                                                input logic [1:0] k1, input logic [7:0] v1,
                                                input logic [1:0] k2, input logic [7:0] v2);
    logic [14:0] a;
    logic [14:0] b;
    int unsigned win;
    int used;
    a = encode_operand(k1, v1);
    b = encode_operand(k2, v2);
    win = 0;
    used = 0;
    if (n >= 1) begin
      win = a[9:0];
      used = a[14:10];
    end
    if (n == 2) begin
      win = win | (32'(b[9:0]) << used);
      used += b[14:10];
    end
    return {5'(used), 20'(win)};
  endfunction

  // Decode one accepted item against the renaming state. A shortage throws
  // away this item's renames but keeps a scope clear.
  task automatic predict_decode(input logic [2:0] op, input logic [19:0] win,
                                input logic [4:0] avail, input logic scope,
                                output decode_result_t res);
    logic [ofd_pkg::ORDER_W-1:0] tab [ofd_pkg::SYMBOL_SLOTS];
    logic                        seen [ofd_pkg::SYMBOL_SLOTS];
    logic [ofd_pkg::ORDER_W-1:0] cnt;
    int unsigned w;
    int lim, pos, n, len, i;
    logic ok;
    logic [1:0] k;
    logic [7:0] v;
    logic [4:0] sym;
    w = win;
    lim = (avail > ofd_pkg::WINDOW_BITS) ? ofd_pkg::WINDOW_BITS : int'(avail);
    if (scope) begin
      for (i = 0; i < ofd_pkg::SYMBOL_SLOTS; i++) begin
        symbol_seen[i] = 1'b0;
        order_of_symbol[i] = '0;
      end
      next_order = '0;
      scope_clears++;
    end
    tab = order_of_symbol;
    seen = symbol_seen;
    cnt = next_order;
    n = operand_total(op);
    ok = 1'b1;
    pos = 0;
    res = '0;
    for (i = 0; i < n && ok; i++) begin
      if (pos + 2 > lim) begin
        ok = 1'b0;
      end else begin
        k = 2'((w >> pos) & 3);
        pos += 2;
        len = (k == ofd_pkg::KIND_VALUE) ? 8 : (k == ofd_pkg::KIND_REG) ? 3 : 5;
        if (pos + len > lim) begin
          ok = 1'b0;
        end else begin
          v = 8'((w >> pos) & ((32'd1 << len) - 1));
          pos += len;
          if (k == ofd_pkg::KIND_STACK || k == ofd_pkg::KIND_PTR) begin
            sym = v[4:0];
            // first sighting in this scope takes the next order number
            if (!seen[sym]) begin
              seen[sym] = 1'b1;
              tab[sym] = cnt;
              cnt = cnt + 1'b1;
            end
            v = 8'(tab[sym]);
          end
          if (i == 0) begin
            res.kind_a = k;
            res.value_a = v;
          end else begin
            res.kind_b = k;
            res.value_b = v;
          end
        end
      end
    end
    if (ok) begin
      order_of_symbol = tab;
      symbol_seen = seen;
      next_order = cnt;
      res.count = 2'(n);
      res.used = 5'(pos);
      res.status = ofd_pkg::STATUS_OK;
    end else begin
      res = '0;
      res.status = ofd_pkg::STATUS_SHORT;
      short_items++;
    end
  endtask

  // Offer one item, hold it until accepted, then record what it should give
  task automatic send_item(input logic [2:0] op, input logic [19:0] win,
                           input logic [4:0] avail, input logic scope);
    decode_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid          <= 1'b1;
    in_opcode         <= op;
    in_operand_bits   <= win;
    in_bits_available <= avail;
    in_new_scope      <= scope;
    do @(posedge clk); while (!in_ready);
    predict_decode(op, win, avail, scope, res);
    expected_decodes.push_back(res);
    items_sent++;
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare every accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    decode_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_decodes.size() == 0) begin
        $error("result with no item pending: count %0d status %0d",
               out_operand_count, out_status);
        errors++;
      end else begin
        want = expected_decodes.pop_front();
        results_checked++;
        if (out_operand_count !== want.count) begin
          $error("operand_count: expected %0d, got %0d", want.count, out_operand_count);
          errors++;
        end
        if (out_first_kind !== want.kind_a) begin
          $error("first_kind: expected %0d, got %0d", want.kind_a, out_first_kind);
          errors++;
        end
        if (out_first_value !== want.value_a) begin
          $error("first_value: expected %0d, got %0d", want.value_a, out_first_value);
          errors++;
        end
        if (out_second_kind !== want.kind_b) begin
          $error("second_kind: expected %0d, got %0d", want.kind_b, out_second_kind);
          errors++;
        end
        if (out_second_value !== want.value_b) begin
          $error("second_value: expected %0d, got %0d", want.value_b, out_second_value);
          errors++;
        end
        if (out_bits_used !== want.used) begin
          $error("bits_used: expected %0d, got %0d", want.used, out_bits_used);
          errors++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          errors++;
        end
      end
    end
  end

  // Field extremes, every opcode, absent operands, shortages at each point,
  // a scope clear on a failing item, oversized availability, same symbol twice
  task automatic test_directed_cases();
    logic [24:0] p;
    send_item(ofd_pkg::OPC_NONE_2, 20'h00000, 5'd0, 1'b1);
    p = pack_operands(1, ofd_pkg::KIND_VALUE, 8'hFF, ofd_pkg::KIND_VALUE, 8'h00);
    send_item(ofd_pkg::OPC_SINGLE_1, p[19:0], p[24:20], 1'b0);
    p = pack_operands(2, ofd_pkg::KIND_VALUE, 8'h00, ofd_pkg::KIND_VALUE, 8'hFF);
    send_item(ofd_pkg::OPC_PAIR_0, p[19:0], 5'd20, 1'b0);
    p = pack_operands(2, ofd_pkg::KIND_REG, 8'd7, ofd_pkg::KIND_REG, 8'd0);
    send_item(ofd_pkg::OPC_PAIR_3, p[19:0], 5'd31, 1'b0);
    // same symbol in both operands: the second sees the first's rename
    p = pack_operands(2, ofd_pkg::KIND_STACK, 8'd5, ofd_pkg::KIND_PTR, 8'd5);
    send_item(ofd_pkg::OPC_PAIR_4, p[19:0], p[24:20], 1'b1);
    p = pack_operands(1, ofd_pkg::KIND_PTR, 8'd31, ofd_pkg::KIND_VALUE, 8'h00);
    send_item(ofd_pkg::OPC_SINGLE_5, p[19:0], p[24:20], 1'b0);
    p = pack_operands(1, ofd_pkg::KIND_STACK, 8'd0, ofd_pkg::KIND_VALUE, 8'h00);
    send_item(ofd_pkg::OPC_SINGLE_6, p[19:0], p[24:20], 1'b0);
    p = pack_operands(1, ofd_pkg::KIND_REG, 8'd3, ofd_pkg::KIND_VALUE, 8'h00);
    send_item(ofd_pkg::OPC_SINGLE_7, p[19:0], 5'd21, 1'b0);
    // shortages: in the second value, in the kind, with nothing available
    p = pack_operands(2, ofd_pkg::KIND_VALUE, 8'hAA, ofd_pkg::KIND_VALUE, 8'h55);
    send_item(ofd_pkg::OPC_PAIR_0, p[19:0], 5'd19, 1'b0);
    send_item(ofd_pkg::OPC_SINGLE_1, 20'h00000, 5'd1, 1'b0);
    send_item(ofd_pkg::OPC_SINGLE_1, 20'hFFFFF, 5'd0, 1'b0);
    // first operand renames, second runs short: rename must not stick
    p = pack_operands(2, ofd_pkg::KIND_STACK, 8'd9, ofd_pkg::KIND_VALUE, 8'h01);
    send_item(ofd_pkg::OPC_PAIR_4, p[19:0], p[24:20] - 5'd1, 1'b0);
    p = pack_operands(1, ofd_pkg::KIND_STACK, 8'd9, ofd_pkg::KIND_VALUE, 8'h00);
    send_item(ofd_pkg::OPC_SINGLE_6, p[19:0], p[24:20], 1'b0);
    // scope clear on an item that then runs short still clears
    p = pack_operands(1, ofd_pkg::KIND_PTR, 8'd12, ofd_pkg::KIND_VALUE, 8'h00);
    send_item(ofd_pkg::OPC_SINGLE_7, p[19:0], 5'd3, 1'b1);
    p = pack_operands(1, ofd_pkg::KIND_PTR, 8'd31, ofd_pkg::KIND_VALUE, 8'h00);
    send_item(ofd_pkg::OPC_SINGLE_5, p[19:0], p[24:20], 1'b0);
    send_item(ofd_pkg::OPC_PAIR_0, 20'hFFFFF, 5'd20, 1'b0);
    send_item(ofd_pkg::OPC_NONE_2, 20'hFFFFF, 5'd31, 1'b0);
    send_item(ofd_pkg::OPC_PAIR_3, 20'hFFFFF, 5'd31, 1'b1);
  endtask

  // Mostly well-formed operations with random content; some noise
  task automatic test_random_stream(input int n_items);
    logic [24:0] p;
    logic [2:0]  op;
    logic [1:0]  k1, k2;
    logic [7:0]  v1, v2;
    logic [19:0] win;
    logic [4:0]  avail, used;
    logic        scope;
    int          sel;
    for (int i = 0; i < n_items; i++) begin
      op = 3'($urandom_range(7));
      scope = ($urandom_range(99) < 3);
      if ($urandom_range(99) < 10) begin
        send_item(op, 20'($urandom), 5'($urandom_range(31)), scope);
      end else begin
        k1 = 2'($urandom_range(3));
        k2 = 2'($urandom_range(3));
        v1 = (k1 == ofd_pkg::KIND_VALUE) ? 8'($urandom_range(255)) :
             (k1 == ofd_pkg::KIND_REG) ? 8'($urandom_range(7)) :
             ($urandom_range(99) < 60) ? 8'($urandom_range(7)) : 8'($urandom_range(31));
        v2 = (k2 == ofd_pkg::KIND_VALUE) ? 8'($urandom_range(255)) :
             (k2 == ofd_pkg::KIND_REG) ? 8'($urandom_range(7)) :
             ($urandom_range(99) < 60) ? 8'($urandom_range(7)) : 8'($urandom_range(31));
        p = pack_operands(operand_total(op), k1, v1, k2, v2);
        used = p[24:20];
        // junk above the last operand
        win = p[19:0] | 20'(32'($urandom) << used);
        sel = $urandom_range(99);
        if (sel < 60)
          avail = 5'($urandom_range(20, used));
        else if (sel < 75)
          avail = used;
        else if (sel < 85)
          avail = 5'($urandom_range(31, 21));
        else
          avail = (used == 0) ? 5'd0 : 5'($urandom_range(used - 1));
        send_item(op, win, avail, scope);
      end
    end
  endtask

  // Receiver holds off for a long stretch while items keep coming
  task automatic test_input_backpressure();
    hold_left = 80;
    test_random_stream(24);
  endtask

  initial begin
    errors = 0;
    items_sent = 0;
    results_checked = 0;
    short_items = 0;
    scope_clears = 0;
    hold_left = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < ofd_pkg::SYMBOL_SLOTS; i++) begin
      symbol_seen[i] = 1'b0;
      order_of_symbol[i] = '0;
    end
    next_order = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = '0;
    in_operand_bits = '0;
    in_bits_available = '0;
    in_new_scope = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 20;
    recv_idle_pct = 57;
    test_directed_cases();
    test_random_stream(360);

    send_idle_pct = 57;
    recv_idle_pct = 20;
    test_random_stream(360);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_input_backpressure();
    test_random_stream(360);

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_decodes.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("Sent %0d items (%0d short of stream bits, %0d scope clears); %0d results checked.",
             items_sent, short_items, scope_clears, results_checked);
    $display("Idle mixes, a long receiver hold-off and symbol renaming were exercised.");
    if (errors == 0 && expected_decodes.size() == 0)
      $display("operand_field_decoder_unit_tb passed");
    else
      $display("operand_field_decoder_unit_tb failed");
    $finish;
  end

  // Run limit, far beyond the slowest legal run
  initial begin
    #5000000;
    $display("operand_field_decoder_unit_tb failed");
    $finish;
  end

endmodule
